// ===== hw/rtl/tlid_pkg.sv =====
// Shared constants and event codes for the terminal line input decoder.
package tlid_pkg;

    // Largest command buffer the decoder supports.
    localparam int unsigned MAX_LINE_BUFFER = 256;
    // Effective size ceiling: the buffer limit, never above 256.
    localparam int unsigned SIZE_CEIL = (MAX_LINE_BUFFER < 256) ? MAX_LINE_BUFFER : 256;

    localparam logic [8:0] CFG_SIZE_RESET = 9'd64;

    // Register index decoded from the APB address.
    localparam logic REG_LINE_BUFFER_SIZE = 1'b0;

    // Byte values of interest.
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBRK = 8'h5B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_UP   = 8'h41;
    localparam logic [7:0] CH_DOWN = 8'h42;
    localparam logic [7:0] CH_FIN_LO   = 8'd64;
    localparam logic [7:0] CH_FIN_HI   = 8'd126;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_APPEND    = 3'd1,
        EV_ERASE     = 3'd2,
        EV_SUBMIT    = 3'd3,
        EV_HIST_UP   = 3'd4,
        EV_HIST_DOWN = 3'd5,
        EV_COMPLETE  = 3'd6
    } t_event;

endpackage

// ===== hw/rtl/terminal_line_input_decoder.sv =====
// Top level of the terminal line input decoder: byte stream in, edit events out.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready    | tdata[7:0] in_byte
//  m_axis    | out       | m_axis_tvalid/tready    | tdata[2:0] event_code, [10:3] event_char,
//            |           |                         |      [18:11] line_position, [23:19] zero
//  apb       | in        | psel/penable/pwrite     | paddr[2] selects register, pwdata[8:0]
//
// Two stages: an input register takes an item, and the decode logic then
// updates the line state and loads the result register. One item per cycle
// sustained while m_axis does not stall.
// Synchronous active-low reset clears the state (previous byte, escape flag,
// line length), sets line_buffer_size to 64 and empties both stages.
// A stall on m_axis holds the result register; the input stage still takes one
// more item before s_axis_tready drops.
module terminal_line_input_decoder
    import tlid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] event_code, [10:3] event_char,
                                        // [18:11] line_position, [23:19] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration register.
    logic [8:0] r_size;

    // Input stage.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Line state.
    logic [7:0] r_prev;
    logic       r_esc;
    logic [7:0] r_len;

    // Result stage.
    logic       r_out_valid;
    t_event     r_code;
    logic [7:0] r_char;
    logic [7:0] r_pos;

    // Next values from the decode.
    logic       n_esc;
    logic [7:0] n_len;
    t_event     n_code;
    logic [7:0] n_char;
    logic [7:0] n_pos;

    logic       adv;       // move the input item into the result register
    logic [8:0] eff_size;
    logic [9:0] len_plus2;
    logic       is_final;
    logic       is_print;
    logic       paired;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LINE_BUFFER_SIZE) ? {23'd0, r_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CFG_SIZE_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_LINE_BUFFER_SIZE) begin
            r_size <= pwdata[8:0];
        end
    end

    // Advance when the result register is free or being drained.
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Limit the size register to the supported ceiling.
    assign eff_size  = (r_size > 9'(SIZE_CEIL)) ? 9'(SIZE_CEIL) : r_size;
    assign len_plus2 = {2'b00, r_len} + 10'd2;
    assign is_final  = (r_in_byte >= CH_FIN_LO) && (r_in_byte <= CH_FIN_HI);
    assign is_print  = (r_in_byte >= CH_PRINT_LO) && (r_in_byte <= CH_FIN_HI);
    assign paired    = (r_prev == CH_CR && r_in_byte == CH_LF) ||
                       (r_prev == CH_LF && r_in_byte == CH_CR);

    always_comb begin
        n_esc  = r_esc;
        n_len  = r_len;
        n_code = EV_NONE;
        n_char = 8'd0;
        n_pos  = 8'd0;
        if (r_esc) begin
            // Swallow parameter bytes; close on a final byte.
            if (is_final) begin
                n_esc = 1'b0;
                if (r_in_byte == CH_UP) begin
                    n_code = EV_HIST_UP;
                end else if (r_in_byte == CH_DOWN) begin
                    n_code = EV_HIST_DOWN;
                end
            end
        end else if (r_prev == CH_ESC && r_in_byte == CH_LBRK) begin
            n_esc = 1'b1;
        end else if (r_in_byte == CH_CR || r_in_byte == CH_LF) begin
            // Count a CR LF or LF CR pair as one line end.
            if (!paired) begin
                n_code = EV_SUBMIT;
                n_pos  = r_len;
                n_len  = 8'd0;
            end
        end else if (r_in_byte == CH_BS || r_in_byte == CH_DEL) begin
            if (r_len != 8'd0) begin
                n_len  = r_len - 8'd1;
                n_code = EV_ERASE;
                n_pos  = r_len - 8'd1;
            end
        end else if (r_in_byte == CH_TAB) begin
            n_code = EV_COMPLETE;
        end else if (is_print) begin
            // Drop the byte once the line is full.
            if (len_plus2 < {1'b0, eff_size}) begin
                n_code = EV_APPEND;
                n_char = r_in_byte;
                n_pos  = r_len;
                n_len  = r_len + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 8'd0;
            r_esc  <= 1'b0;
            r_len  <= 8'd0;
        end else if (adv) begin
            r_prev <= r_in_byte;
            r_esc  <= n_esc;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_code <= n_code;
            r_char <= n_char;
            r_pos  <= n_pos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_pos, r_char, r_code};

    // The line never grows past 254 bytes.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != 8'd255)
        else $error("line length out of range");

    // Escape mode is entered only by a '[' byte.
    a_esc_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_esc) |-> r_prev == CH_LBRK)
        else $error("escape entered without bracket");

    // An append carries a printable byte; any other event carries zero.
    a_append_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_code == EV_APPEND) |-> (r_char >= CH_PRINT_LO && r_char <= CH_FIN_HI))
        else $error("append of non-printable byte");

    a_other_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_code != EV_APPEND) |-> r_char == 8'd0)
        else $error("event char set on non-append");

endmodule

// ===== verif/tlid_event_checker.sv =====
// Checker for the terminal line input decoder: predicts line-edit events and compares results.
`timescale 1ns / 1ps

module tlid_event_checker
    import tlid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,     // [7:0] in_byte

    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,    // [2:0] event_code, [10:3] event_char,
                                       // [18:11] line_position, [23:19] zero

    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,

    output int unsigned o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        t_event     code;
        logic [7:0] ch;
        logic [7:0] pos;
    } t_line_event;

    t_line_event pending_events [$];
    t_line_event got_event;

    logic [8:0] buf_size;
    logic [7:0] last_byte;
    logic       in_escape;
    logic [7:0] line_len;

    int unsigned mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Advance the line state by one byte and return the edit event it causes.
    function automatic t_line_event decode_byte(input logic [7:0] c);
        t_line_event ev;
        int unsigned size_lim;
        ev.code = EV_NONE;
        ev.ch   = '0;
        ev.pos  = '0;
        size_lim = (buf_size > SIZE_CEIL) ? SIZE_CEIL : buf_size;
        if (in_escape) begin
            if (c >= CH_FIN_LO && c <= CH_FIN_HI) begin
                in_escape = 1'b0;
                if (c == CH_UP)
                    ev.code = EV_HIST_UP;
                else if (c == CH_DOWN)
                    ev.code = EV_HIST_DOWN;
            end
        end else if (last_byte == CH_ESC && c == CH_LBRK) begin
            in_escape = 1'b1;
        end else if (c == CH_CR || c == CH_LF) begin
            // CR LF and LF CR count as one line end
            if (!((last_byte == CH_CR && c == CH_LF) || (last_byte == CH_LF && c == CH_CR))) begin
                ev.code  = EV_SUBMIT;
                ev.pos   = line_len;
                line_len = '0;
            end
        end else if (c == CH_BS || c == CH_DEL) begin
            if (line_len != 0) begin
                line_len = line_len - 8'd1;
                ev.code  = EV_ERASE;
                ev.pos   = line_len;
            end
        end else if (c == CH_TAB) begin
            ev.code = EV_COMPLETE;
        end else if (c >= CH_PRINT_LO && c <= CH_FIN_HI) begin
            // two bytes of the buffer stay reserved
            if (int'(line_len) + 2 < int'(size_lim)) begin
                ev.code  = EV_APPEND;
                ev.ch    = c;
                ev.pos   = line_len;
                line_len = line_len + 8'd1;
            end
        end
        last_byte = c;
        return ev;
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            buf_size  = CFG_SIZE_RESET;
            last_byte = '0;
            in_escape = 1'b0;
            line_len  = '0;
            pending_events.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[2] == REG_LINE_BUFFER_SIZE)
                buf_size = i_pwdata[8:0];

            if (i_out_valid && i_out_ready) begin
                if (pending_events.size() == 0) begin
                    $error("unexpected result: event_code %0d, line_position %0d",
                           i_out_data[2:0], i_out_data[18:11]);
                    mismatch_count++;
                end else begin
                    got_event = pending_events.pop_front();
                    compare_field("event_code", got_event.code, i_out_data[2:0]);
                    compare_field("event_char", got_event.ch, i_out_data[10:3]);
                    compare_field("line_position", got_event.pos, i_out_data[18:11]);
                    compare_field("tdata padding", 0, i_out_data[23:19]);
                end
            end

            if (i_in_valid && i_in_ready)
                pending_events.push_back(decode_byte(i_in_data));
        end
        o_outstanding <= pending_events.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the terminal line input decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
    import tlid_pkg::*;

    localparam int NUM_PHASES   = 10;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the pipeline
    localparam int QUIET_LIMIT  = 3000;  // cycles with no traffic before giving up
    localparam int RANDOM_ITEMS = 30;    // random items per configuration phase
    localparam int LONG_RUN     = 258;   // enough printables to hit the 254-byte cap
    localparam logic [2:0] SIZE_ADDR     = {REG_LINE_BUFFER_SIZE, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] in_byte

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [2:0] event_code, [10:3] event_char,
                                       // [18:11] line_position, [23:19] zero

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatches;
    int          outstanding;

    // Flow-control knobs, percent of cycles
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    bit          hold_req = 1'b0;

    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;

    // Sizes per phase: tiny, zero, clamped maximum, exact maximum, ignored-below-3 ...
    int unsigned phase_size [NUM_PHASES] = '{3, 0, 511, 256, 2, 12, 257, 130, 1, 64};

    always #2 i_clk = ~i_clk;

    terminal_line_input_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tlid_event_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Offer one byte, with random idle cycles ahead of it, and wait for the handshake.
    // Valid stays high into the next call unless that call idles first.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // One random token: mostly well-formed typing, line ends and escape sequences,
    // with broken escapes and raw noise mixed in.
    task automatic send_token();
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(99);
        if (roll < 55) begin
            send_byte(8'($urandom_range(126, 32)));
        end else if (roll < 63) begin
            send_byte($urandom_range(1) ? CH_BS : CH_DEL);
        end else if (roll < 70) begin
            case ($urandom_range(3))
                0: send_byte(CH_CR);
                1: send_byte(CH_LF);
                2: begin
                    send_byte(CH_CR);
                    send_byte(CH_LF);
                end
                default: begin
                    send_byte(CH_LF);
                    send_byte(CH_CR);
                end
            endcase
        end else if (roll < 80) begin
            // full CSI sequence: parameters, then a final byte biased to the arrows
            send_byte(CH_ESC);
            send_byte(CH_LBRK);
            n = $urandom_range(3);
            repeat (n) send_byte(8'($urandom_range(63, 48)));
            case ($urandom_range(3))
                0: send_byte(CH_UP);
                1: send_byte(CH_DOWN);
                default: send_byte(8'($urandom_range(126, 64)));
            endcase
        end else if (roll < 85) begin
            // broken escape: lone ESC or an unfinished sequence
            send_byte(CH_ESC);
            if ($urandom_range(1))
                send_byte(CH_LBRK);
            send_byte(8'($urandom_range(255)));
        end else if (roll < 89) begin
            send_byte(CH_TAB);
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic send_random(input int unsigned count);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target) send_token();
    endtask

    // Drop valid and hold until every expected event has come back.
    // The first edge lets the checker count the item taken at this step.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: random stalls, or one long hold-off when asked, counted here.
    initial begin
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: any handshake or register access counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset size of 64, no idling.
        send_byte("A");                             // append at 0
        send_byte(" ");                             // lowest printable
        send_byte("~");                             // highest printable
        send_byte(8'h1F);                           // control byte, ignored
        send_byte(CH_DEL);                          // erase both ways
        send_byte(CH_BS);
        send_byte(CH_TAB);                          // completion
        send_byte(CH_ESC); send_byte(CH_LBRK); send_byte(CH_UP);
        send_byte(CH_ESC); send_byte(CH_LBRK); send_byte(CH_DOWN);
        send_byte(CH_ESC); send_byte(CH_LBRK); send_byte("1"); send_byte("C");
        send_byte(CH_ESC); send_byte("x");          // ESC not followed by '['
        send_byte(CH_CR);  send_byte(CH_LF);        // CR LF submits once
        send_byte(CH_LF);  send_byte(CH_CR);        // LF CR submits once
        send_byte(CH_CR);                           // second CR submits again
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
        send_byte(CH_BS);                           // erase on an empty line
        send_random(RANDOM_ITEMS);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            apb_write(SIZE_ADDR, phase_size[p]);
            // A write beyond the register list must leave the size alone.
            if (p == 2)
                apb_write(UNMAPPED_ADDR, 32'd3);
            case (p % 4)
                0: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct = 46;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct = 46;
                end
                default: begin
                    gap_pct = 20;
                    stall_pct = 20;
                end
            endcase

            // Large buffers: type past the cap so the full-line drop is reached.
            if (phase_size[p] >= 256)
                repeat (LONG_RUN) send_byte(8'($urandom_range(126, 32)));

            if (p == 4) begin
                // Stop the receiver for a long stretch while bytes keep coming.
                send_random(RANDOM_ITEMS / 3);
                hold_req = 1'b1;
                send_random(RANDOM_ITEMS - RANDOM_ITEMS / 3);
            end else if (p == 5) begin
                // Pause the sender mid-phase until every result is back.
                send_random(RANDOM_ITEMS / 2);
                drain();
                send_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
            end else begin
                send_random(RANDOM_ITEMS);
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
